// File: rtl/core/sat_pkg.sv
// Shared types, constants and codes for the section address translator.
package sat_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);

    localparam int ADDR_W       = 32;
    localparam int ENTRY_IDX_W  = 4;
    localparam int COUNT_W      = 5;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;

    // input commands
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TO_FILE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TO_MEM  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_PASS  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_ALIGN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECT_ALIGN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECT_COUNT   = 2'd3;

    localparam logic [ADDR_W-1:0] FILE_ALIGN_RESET = 32'd512;
    localparam logic [ADDR_W-1:0] SECT_ALIGN_RESET = 32'd4096;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0] virtual_base;
        logic [ADDR_W-1:0] virtual_size;
        logic [ADDR_W-1:0] raw_base;
        logic [ADDR_W-1:0] raw_size;
    } entry_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        idx_t   raddr;
    } mem_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  header_size;
        logic [ADDR_W-1:0]  file_alignment;
        logic [ADDR_W-1:0]  section_alignment;
        logic [COUNT_W-1:0] section_count;
    } cfg_t;

endpackage

// File: rtl/core/sat_table.sv
// Section descriptor table: one write port, one registered read port.
module sat_table
    import sat_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rdata
);

    entry_t mem [MAX_SECTIONS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// File: rtl/core/sat_search.sv
// Command sequencer: table writes, first-match section search, result register.
module sat_search
    import sat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CMD_W-1:0]       in_cmd,
    input  logic [ENTRY_IDX_W-1:0] in_idx,
    input  entry_t                 in_entry,
    input  logic [ADDR_W-1:0]      in_query,
    output mem_req_t               mem_req,
    input  entry_t                 mem_rdata,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ADDR_W-1:0]      out_addr,
    output logic [STATUS_W-1:0]    out_status
);

    typedef enum logic [1:0] {IDLE, SEARCH, FLUSH} state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                to_file_reg, to_file_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;
    idx_t                cur_reg, cur_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [STATUS_W-1:0] out_st_reg, out_st_next;

    logic                accept;
    logic                passthru;
    logic [CNT_W-1:0]    limit;
    logic [CNT_W-1:0]    cur_plus;
    logic [ADDR_W-1:0]   from_base;
    logic [ADDR_W-1:0]   from_size;
    logic [ADDR_W-1:0]   to_base;
    logic [ADDR_W:0]     range_end;
    logic                hit;
    logic [ADDR_W-1:0]   xlat;

    assign in_ready = (state_reg == IDLE);
    assign accept   = in_valid && in_ready;
    assign passthru = (in_query < cfg.header_size) ||
                      (cfg.file_alignment == cfg.section_alignment);
    assign limit    = (32'(cfg.section_count) > 32'(MAX_SECTIONS)) ?
                      CNT_W'(MAX_SECTIONS) : CNT_W'(cfg.section_count);
    assign cur_plus = CNT_W'(cur_reg) + CNT_W'(1);

    // entry cur_reg is on the read port during SEARCH
    assign from_base = to_file_reg ? mem_rdata.virtual_base : mem_rdata.raw_base;
    assign from_size = to_file_reg ? mem_rdata.virtual_size : mem_rdata.raw_size;
    assign to_base   = to_file_reg ? mem_rdata.raw_base : mem_rdata.virtual_base;
    assign range_end = {1'b0, from_base} + {1'b0, from_size};
    assign hit       = (addr_reg >= from_base) && ({1'b0, addr_reg} < range_end);
    assign xlat      = to_base + (addr_reg - from_base);

    // writes happen only in IDLE, so a search never sees a write in flight
    always_comb
    begin
        mem_req.we    = accept && (in_cmd == CMD_WRITE) &&
                        (32'(in_idx) < 32'(MAX_SECTIONS));
        mem_req.waddr = IDX_W'(in_idx);
        mem_req.wdata = in_entry;
        mem_req.raddr = (state_reg == SEARCH) ? IDX_W'(cur_plus) : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        to_file_next   = to_file_reg;
        limit_next     = limit_reg;
        cur_next       = cur_reg;
        res_addr_next  = res_addr_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_addr_next  = out_addr_reg;
        out_st_next    = out_st_reg;

        case (state_reg)
            IDLE:
            begin
                if (accept && (in_cmd inside {CMD_TO_FILE, CMD_TO_MEM}))
                begin
                    addr_next    = in_query;
                    to_file_next = (in_cmd == CMD_TO_FILE);
                    limit_next   = limit;
                    cur_next     = '0;
                    if (passthru)
                    begin
                        res_addr_next = in_query;
                        res_st_next   = ST_PASS;
                        state_next    = FLUSH;
                    end
                    else if (limit == '0)
                    begin
                        res_addr_next = '0;
                        res_st_next   = ST_MISS;
                        state_next    = FLUSH;
                    end
                    else
                    begin
                        state_next = SEARCH;
                    end
                end
            end
            SEARCH:
            begin
                if (hit)
                begin
                    res_addr_next = xlat;
                    res_st_next   = ST_FOUND;
                    state_next    = FLUSH;
                end
                else if (cur_plus == limit_reg)
                begin
                    res_addr_next = '0;
                    res_st_next   = ST_MISS;
                    state_next    = FLUSH;
                end
                else
                begin
                    cur_next = IDX_W'(cur_plus);
                end
            end
            FLUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_st_next    = res_st_reg;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            addr_reg      <= '0;
            to_file_reg   <= 1'b0;
            limit_reg     <= '0;
            cur_reg       <= '0;
            res_addr_reg  <= '0;
            res_st_reg    <= ST_PASS;
            out_valid_reg <= 1'b0;
            out_addr_reg  <= '0;
            out_st_reg    <= ST_PASS;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            to_file_reg   <= to_file_next;
            limit_reg     <= limit_next;
            cur_reg       <= cur_next;
            res_addr_reg  <= res_addr_next;
            res_st_reg    <= res_st_next;
            out_valid_reg <= out_valid_next;
            out_addr_reg  <= out_addr_next;
            out_st_reg    <= out_st_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_status = out_st_reg;

endmodule

// File: rtl/core/section_address_translator_top.sv
// A table write is stored when accepted; a pass-through result, or a miss with a count of 0,
// goes from IDLE through FLUSH to the output register; a search checks entries from 0 upward,
// stops at the first hit or after the last counted entry, then passes FLUSH. Throughput: one item
// at a time, the table's single read port checking one section descriptor per cycle in SEARCH.
// Reset: configuration returns to header 0, alignments 512/4096, count 0; table contents stay
// undefined until written, with no clearing pass.
module section_address_translator_top
    import sat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] entry_index, [35:4] entry_virtual_base, [67:36] entry_virtual_size,
    // [99:68] entry_raw_base, [131:100] entry_raw_size, [163:132] query_address, rest zero
    input  logic [167:0]           s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]       s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] translated_address
    output logic [ADDR_W-1:0]      m_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]    m_tuser
);

    cfg_t     cfg_reg;
    mem_req_t mem_req;
    entry_t   mem_rdata;
    entry_t   in_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_size       <= '0;
            cfg_reg.file_alignment    <= FILE_ALIGN_RESET;
            cfg_reg.section_alignment <= SECT_ALIGN_RESET;
            cfg_reg.section_count     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER_SIZE: cfg_reg.header_size       <= cfg_data;
                REG_FILE_ALIGN:  cfg_reg.file_alignment    <= cfg_data;
                REG_SECT_ALIGN:  cfg_reg.section_alignment <= cfg_data;
                REG_SECT_COUNT:  cfg_reg.section_count     <= cfg_data[COUNT_W-1:0];
                default:         cfg_reg.header_size       <= cfg_reg.header_size;
            endcase
        end
    end

    assign in_entry.virtual_base = s_tdata[35:4];
    assign in_entry.virtual_size = s_tdata[67:36];
    assign in_entry.raw_base     = s_tdata[99:68];
    assign in_entry.raw_size     = s_tdata[131:100];

    sat_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_idx     (s_tdata[3:0]),
        .in_entry   (in_entry),
        .in_query   (s_tdata[163:132]),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (m_tdata),
        .out_status (m_tuser)
    );

    sat_table u_table (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

// File: rtl/core/sat_checker.sv
// Port-level checks for the section address translator, bound to the top level.
module sat_checker
    import sat_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [CMD_W-1:0]    s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [ADDR_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0] m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_PASS) || (m_tuser == ST_FOUND) || (m_tuser == ST_MISS))
        else $error("undefined status code");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_MISS) |-> (m_tdata == '0))
        else $error("miss with nonzero address");

    // a table write or an unused command never raises a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && ((s_tuser == CMD_WRITE) || (s_tuser == CMD_NONE)) && !m_tvalid
        |=> !m_tvalid)
        else $error("result after write transfer");

endmodule

bind section_address_translator_top sat_checker u_sat_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
